// ===== rtl/cna_pkg.sv =====
// Shared constants and the item record carried along the complex ALU pipeline.
`timescale 1ns / 1ps
package cna_pkg;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;

    localparam int unsigned QBITS   = 32;
    localparam int unsigned DEN_W   = 64;
    localparam int unsigned REM_W   = 96;
    localparam int unsigned NCELLS  = QBITS;

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic              neg_re;
        logic              neg_im;
        logic              sat_re;
        logic              sat_im;
        logic [DEN_W-1:0]  den;
        logic [REM_W-1:0]  rem_re;
        logic [REM_W-1:0]  rem_im;
        logic [QBITS-1:0]  q_re;
        logic [QBITS-1:0]  q_im;
        logic [31:0]       res_re;
        logic [31:0]       res_im;
        logic              ovf;
    } cna_item_t;

endpackage

// ===== rtl/cna_front.sv =====
// Front stages: products, sums, scaling and saturation of non-divide results and divider set-up.
`timescale 1ns / 1ps
module cna_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             action,
    input  logic signed [31:0]     a_re,
    input  logic signed [31:0]     a_im,
    input  logic signed [31:0]     b_re,
    input  logic signed [31:0]     b_im,
    output logic                   item_valid,
    input  logic                   item_ready,
    output cna_pkg::cna_item_t     item
);

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    function automatic sat_t sat66(input logic signed [65:0] x);
        sat_t r;
        r.ovf = 1'b0;
        r.val = x[31:0];
        if (x > 66'sh0_7FFF_FFFF) begin
            r.val = 32'h7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (x < -66'sh0_8000_0000) begin
            r.val = 32'h8000_0000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // stage 1: products and simple results
    logic              v1_reg;
    logic [2:0]        op1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    sat_t              s1_re_reg, s1_im_reg;
    // stage 2: sums
    logic              v2_reg;
    logic [2:0]        op2_reg;
    logic signed [65:0] x_reg, y_reg;
    logic [63:0]       den_reg;
    sat_t              s2_re_reg, s2_im_reg;
    // stage 3: item into the divider row
    logic              v3_reg;
    cna_pkg::cna_item_t item_reg;

    logic rdy1, rdy2, rdy3;
    assign rdy3     = !v3_reg || item_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    logic signed [65:0] are_x, aim_x, bre_x, bim_x;
    sat_t simple_re, simple_im;
    assign are_x = 66'(a_re);
    assign aim_x = 66'(a_im);
    assign bre_x = 66'(b_re);
    assign bim_x = 66'(b_im);

    always_comb
    begin
        simple_re = '0;
        simple_im = '0;
        unique case (action)
            cna_pkg::OP_ADD:
            begin
                simple_re = sat66(are_x + bre_x);
                simple_im = sat66(aim_x + bim_x);
            end
            cna_pkg::OP_SUB:
            begin
                simple_re = sat66(are_x - bre_x);
                simple_im = sat66(aim_x - bim_x);
            end
            cna_pkg::OP_CONJ:
            begin
                simple_re = sat66(are_x);
                simple_im = sat66(-aim_x);
            end
            default:
            begin
                simple_re = '0;
                simple_im = '0;
            end
        endcase
    end

    logic signed [65:0] x_next, y_next;
    always_comb
    begin
        if (op1_reg == cna_pkg::OP_MUL)
        begin
            x_next = 66'(p_rr_reg) - 66'(p_ii_reg);
            y_next = 66'(p_ri_reg) + 66'(p_ir_reg);
        end
        else
        begin
            x_next = 66'(p_rr_reg) + 66'(p_ii_reg);
            y_next = 66'(p_ir_reg) - 66'(p_ri_reg);
        end
    end

    // stage 3 combinational set-up
    cna_pkg::cna_item_t item_next;
    logic signed [65:0] x_sh, y_sh, x_abs, y_abs;
    logic [95:0] n_re, n_im, d_top;
    always_comb
    begin
        x_sh  = x_reg >>> FRAC_BITS;
        y_sh  = y_reg >>> FRAC_BITS;
        x_abs = x_reg[65] ? -x_reg : x_reg;
        y_abs = y_reg[65] ? -y_reg : y_reg;
        n_re  = {32'b0, x_abs[63:0]} << FRAC_BITS;
        n_im  = {32'b0, y_abs[63:0]} << FRAC_BITS;
        d_top = {den_reg, 32'b0};
        item_next        = '0;
        item_next.den    = den_reg;
        item_next.res_re = s2_re_reg.val;
        item_next.res_im = s2_im_reg.val;
        item_next.ovf    = s2_re_reg.ovf | s2_im_reg.ovf;
        if (op2_reg == cna_pkg::OP_MUL)
        begin
            item_next.res_re = sat66(x_sh).val;
            item_next.res_im = sat66(y_sh).val;
            item_next.ovf    = sat66(x_sh).ovf | sat66(y_sh).ovf;
        end
        else if (op2_reg == cna_pkg::OP_DIV)
        begin
            item_next.is_div = 1'b1;
            item_next.ovf    = 1'b0;
            item_next.dz     = (den_reg == '0);
            item_next.neg_re = x_reg[65];
            item_next.neg_im = y_reg[65];
            item_next.sat_re = (n_re >= d_top);
            item_next.sat_im = (n_im >= d_top);
            item_next.rem_re = n_re;
            item_next.rem_im = n_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            op1_reg   <= action;
            p_rr_reg  <= 64'(a_re) * 64'(b_re);
            p_ii_reg  <= 64'(a_im) * 64'(b_im);
            p_ri_reg  <= 64'(a_re) * 64'(b_im);
            p_ir_reg  <= 64'(a_im) * 64'(b_re);
            sq_r_reg  <= 64'(b_re) * 64'(b_re);
            sq_i_reg  <= 64'(b_im) * 64'(b_im);
            s1_re_reg <= simple_re;
            s1_im_reg <= simple_im;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg   <= op1_reg;
            x_reg     <= x_next;
            y_reg     <= y_next;
            den_reg   <= 64'(sq_r_reg) + 64'(sq_i_reg);
            s2_re_reg <= s1_re_reg;
            s2_im_reg <= s1_im_reg;
        end
        if (rdy3 && v2_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = v3_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/cna_div_cell.sv =====
// One restoring-division cell: decides one quotient bit for both parts.
`timescale 1ns / 1ps
module cna_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cna_pkg::cna_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output cna_pkg::cna_item_t dn_item
);

    logic               v_reg;
    cna_pkg::cna_item_t item_reg, item_next;
    logic [cna_pkg::REM_W-1:0] dd, r_re, r_im;
    logic ge_re, ge_im;

    assign up_ready = !v_reg || dn_ready;

    always_comb
    begin
        dd        = {1'b0, up_item.den, 31'b0};
        ge_re     = up_item.rem_re >= dd;
        ge_im     = up_item.rem_im >= dd;
        r_re      = ge_re ? up_item.rem_re - dd : up_item.rem_re;
        r_im      = ge_im ? up_item.rem_im - dd : up_item.rem_im;
        item_next        = up_item;
        item_next.rem_re = {r_re[cna_pkg::REM_W-2:0], 1'b0};
        item_next.rem_im = {r_im[cna_pkg::REM_W-2:0], 1'b0};
        item_next.q_re   = {up_item.q_re[cna_pkg::QBITS-2:0], ge_re};
        item_next.q_im   = {up_item.q_im[cna_pkg::QBITS-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

    assign dn_valid = v_reg;
    assign dn_item  = item_reg;

endmodule

// ===== rtl/cna_back.sv =====
// Output stage: sign and saturate the quotient, pick the result, hold it.
`timescale 1ns / 1ps
module cna_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cna_pkg::cna_item_t up_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        res_re,
    output logic [31:0]        res_im,
    output logic               overflow,
    output logic               div_zero
);

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } part_t;

    function automatic part_t qsat(input logic neg, input logic sat, input logic [31:0] q);
        part_t r;
        r.ovf = 1'b0;
        r.val = neg ? -q : q;
        if (neg && (sat || q > 32'h8000_0000))
        begin
            r.val = 32'h8000_0000;
            r.ovf = 1'b1;
        end
        else if (!neg && (sat || q > 32'h7FFF_FFFF))
        begin
            r.val = 32'h7FFF_FFFF;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    logic  v_reg, ovf_reg, dz_reg;
    logic [31:0] re_reg, im_reg;
    part_t pre, pim;
    logic [31:0] re_next, im_next;
    logic ovf_next, dz_next;

    assign up_ready = !v_reg || out_ready;

    always_comb
    begin
        pre      = qsat(up_item.neg_re, up_item.sat_re, up_item.q_re);
        pim      = qsat(up_item.neg_im, up_item.sat_im, up_item.q_im);
        re_next  = up_item.res_re;
        im_next  = up_item.res_im;
        ovf_next = up_item.ovf;
        dz_next  = 1'b0;
        if (up_item.is_div && up_item.dz)
        begin
            re_next  = '0;
            im_next  = '0;
            ovf_next = 1'b0;
            dz_next  = 1'b1;
        end
        else if (up_item.is_div)
        begin
            re_next  = pre.val;
            im_next  = pim.val;
            ovf_next = pre.ovf | pim.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
            dz_reg  <= dz_next;
        end
    end

    assign out_valid = v_reg;
    assign res_re    = re_reg;
    assign res_im    = im_reg;
    assign overflow  = ovf_reg;
    assign div_zero  = dz_reg;

endmodule

// ===== rtl/complex_number_alu_top.sv =====
// Top level of the complex ALU: front stages, a row of divider cells, output stage.
// Path from acceptance to result: 3 front stages, 32 divider cells and 1 output
//   register; every operation takes the same path and each stage holds its own valid bit.
// Throughput: one item per cycle unless out_ready stalls the pipeline; stages fill bubbles.
// Reset: rst_n clears every valid bit asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
module complex_number_alu_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               overflow,
    output logic               div_zero
);

    // Link k feeds cell k; link NCELLS feeds the output stage.
    cna_pkg::cna_item_t              link_item  [cna_pkg::NCELLS+1];
    logic [cna_pkg::NCELLS:0]        link_valid;
    logic [cna_pkg::NCELLS:0]        link_ready;

    // Products, sums, finished add/sub/mul/conj results and divider operands.
    cna_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .a_re       (a_re),
        .a_im       (a_im),
        .b_re       (b_re),
        .b_im       (b_im),
        .item_valid (link_valid[0]),
        .item_ready (link_ready[0]),
        .item       (link_item[0])
    );

    // Each cell settles one quotient bit, most significant first, and advances
    // the item to its neighbour; non-divide items simply ride along.
    for (genvar k = 0; k < cna_pkg::NCELLS; k++)
    begin : g_cell
        cna_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_item  (link_item[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_item  (link_item[k+1])
        );
    end

    logic [31:0] res_re_w, res_im_w;

    // Apply the sign, saturate the quotient and hold the result for the consumer.
    cna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (link_valid[cna_pkg::NCELLS]),
        .up_ready  (link_ready[cna_pkg::NCELLS]),
        .up_item   (link_item[cna_pkg::NCELLS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re_w),
        .res_im    (res_im_w),
        .overflow  (overflow),
        .div_zero  (div_zero)
    );

    assign res_re = $signed(res_re_w);
    assign res_im = $signed(res_im_w);

endmodule

// ===== rtl/cna_checker.sv =====
// Port-level checks for the complex ALU, bound to the top level.
`timescale 1ns / 1ps
module cna_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] res_re,
    input logic signed [31:0] res_im,
    input logic               overflow,
    input logic               div_zero
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
        && $stable(overflow) && $stable(div_zero))
        else $error("result changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> res_re == 32'sd0 && res_im == 32'sd0)
        else $error("zero divisor gave non-zero result");

    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> !overflow)
        else $error("zero divisor flagged overflow");

    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
        res_re == 32'sh7FFF_FFFF || res_re == -32'sh8000_0000 ||
        res_im == 32'sh7FFF_FFFF || res_im == -32'sh8000_0000)
        else $error("overflow without a saturated part");

endmodule

bind complex_number_alu_top cna_port_checker u_cna_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_re    (res_re),
    .res_im    (res_im),
    .overflow  (overflow),
    .div_zero  (div_zero)
);
